// File: src/pms_pkg.sv
// Shared types, widths and constants for the PID motor speed loop.
`timescale 1ns / 1ps

package pms_pkg;

    // Field and state widths
    localparam int TIME_BITS_DEF = 32;
    localparam int TIME_W        = 32;
    localparam int POS_W         = 32;
    localparam int CFG_W         = 24;
    localparam int CFG_ADDR_W    = 2;
    localparam int DUTY_W        = 8;
    localparam int DIFF_W        = 33;
    localparam int ERR_W         = 32;
    localparam int INTEG_W       = 48;
    localparam int DERIV_W       = 40;
    localparam int SUM_W         = 49;
    localparam int LVL_W         = 32;
    localparam int GAP_W         = 9;

    localparam int GAP_LIMIT_MS  = 500;
    localparam int ITERM_DIV     = 1000;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D = 2'd3;

    // Level clamp window, Q.8
    localparam logic signed [LVL_W-1:0] LEVEL_MIN = LVL_W'(170 * 256);
    localparam logic signed [LVL_W-1:0] LEVEL_MAX = LVL_W'(255 * 256);

    // Shared multiply/divide unit
    localparam int ARG_W      = 48;
    localparam int B_W        = 24;
    localparam int ACC_W      = 64;
    localparam int STEP_W     = 5;
    localparam int DIV_W      = 10;
    localparam int T_W        = DIV_W + 2;
    localparam int FRAC_BITS  = 16;
    localparam int MUL_STEPS  = B_W / 2;
    // gap digits, then zero digits that scale by 65536 ahead of the final shift
    localparam int MULG_STEPS = (GAP_W + 2) / 2 + FRAC_BITS / 2;
    localparam int DIV_STEPS  = ARG_W / 2;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic                    start;
        arith_op_t               op;
        logic [STEP_W-1:0]       steps;
        logic signed [ARG_W-1:0] a;
        logic [B_W-1:0]          b;
    } arith_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] result;
    } arith_rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0]       now_ms;
        logic signed [POS_W-1:0] distance_sample;
    } in_t;

    typedef struct packed {
        logic              dir_a;
        logic              dir_b;
        logic [DUTY_W-1:0] duty;
    } out_t;

endpackage

// File: src/pms_arith.sv
// Shared radix-4 unit: Booth multiply with /65536 truncation, or signed divide by a small divisor.
`timescale 1ns / 1ps

module pms_arith (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pms_pkg::arith_req_t  req,
    output pms_pkg::arith_rsp_t  rsp
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_STEP = 3'b010,
        PH_FIX  = 3'b100
    } phase_t;

    phase_t                            phase_reg, phase_next;
    pms_pkg::arith_op_t                op_reg, op_next;
    logic [pms_pkg::STEP_W-1:0]        cnt_reg, cnt_next;
    logic                              done_reg, done_next;
    logic signed [pms_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [pms_pkg::ACC_W-1:0]  mcand_reg, mcand_next;
    logic [pms_pkg::B_W:0]             mplier_reg, mplier_next;
    logic [pms_pkg::DIV_W-1:0]         rem_reg, rem_next;
    logic [pms_pkg::T_W-1:0]           dvs1_reg, dvs1_next;
    logic [pms_pkg::T_W-1:0]           dvs2_reg, dvs2_next;
    logic [pms_pkg::T_W-1:0]           dvs3_reg, dvs3_next;
    logic                              neg_reg, neg_next;

    logic [pms_pkg::ARG_W-1:0]         mag;
    logic [pms_pkg::T_W-1:0]           d1, d2;
    logic [pms_pkg::T_W-1:0]           trem, rnew;
    logic [1:0]                        qdig;
    logic signed [pms_pkg::ACC_W-1:0]  addend;
    logic [pms_pkg::ACC_W-1:0]         bias;
    logic signed [pms_pkg::ACC_W-1:0]  biased;

    always_comb begin
        phase_next  = phase_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        dvs1_next   = dvs1_reg;
        dvs2_next   = dvs2_reg;
        dvs3_next   = dvs3_reg;
        neg_next    = neg_reg;
        done_next   = (phase_reg == PH_FIX);

        mag = req.a[pms_pkg::ARG_W-1] ? -req.a : req.a;
        d1  = pms_pkg::T_W'(req.b[pms_pkg::DIV_W-1:0]);
        d2  = d1 << 1;

        // one quotient digit: compare against d, 2d and 3d
        trem = {rem_reg, acc_reg[pms_pkg::ARG_W-1 -: 2]};
        if (trem >= dvs3_reg) begin
            qdig = 2'd3;
            rnew = trem - dvs3_reg;
        end else if (trem >= dvs2_reg) begin
            qdig = 2'd2;
            rnew = trem - dvs2_reg;
        end else if (trem >= dvs1_reg) begin
            qdig = 2'd1;
            rnew = trem - dvs1_reg;
        end else begin
            qdig = 2'd0;
            rnew = trem;
        end

        case (mplier_reg[pms_pkg::B_W -: 3])
            3'b001, 3'b010: addend = mcand_reg;
            3'b011:         addend = mcand_reg <<< 1;
            3'b100:         addend = -(mcand_reg <<< 1);
            3'b101, 3'b110: addend = -mcand_reg;
            default:        addend = '0;
        endcase

        // bias negative products so the shift truncates toward zero
        bias   = acc_reg[pms_pkg::ACC_W-1]
               ? pms_pkg::ACC_W'((1 << pms_pkg::FRAC_BITS) - 1) : '0;
        biased = acc_reg + $signed(bias);

        case (phase_reg)
            PH_IDLE: begin
                if (req.start) begin
                    op_next    = req.op;
                    cnt_next   = req.steps;
                    phase_next = PH_STEP;
                    if (req.op == pms_pkg::OP_DIV) begin
                        acc_next  = {{(pms_pkg::ACC_W - pms_pkg::ARG_W){1'b0}}, mag};
                        rem_next  = '0;
                        neg_next  = req.a[pms_pkg::ARG_W-1];
                        dvs1_next = d1;
                        dvs2_next = d2;
                        dvs3_next = d1 + d2;
                    end else begin
                        acc_next    = '0;
                        mcand_next  = pms_pkg::ACC_W'($signed(req.a));
                        mplier_next = {req.b, 1'b0};
                    end
                end
            end
            PH_STEP: begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == pms_pkg::STEP_W'(1)) begin
                    phase_next = PH_FIX;
                end
                if (op_reg == pms_pkg::OP_DIV) begin
                    acc_next = {{(pms_pkg::ACC_W - pms_pkg::ARG_W){1'b0}},
                                acc_reg[pms_pkg::ARG_W-3:0], qdig};
                    rem_next = rnew[pms_pkg::DIV_W-1:0];
                end else begin
                    acc_next    = (acc_reg <<< 2) + addend;
                    mplier_next = mplier_reg << 2;
                end
            end
            PH_FIX: begin
                phase_next = PH_IDLE;
                if (op_reg == pms_pkg::OP_DIV) begin
                    acc_next = neg_reg ? -acc_reg : acc_reg;
                end else begin
                    acc_next = biased >>> pms_pkg::FRAC_BITS;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        dvs1_reg   <= dvs1_next;
        dvs2_reg   <= dvs2_next;
        dvs3_reg   <= dvs3_next;
        neg_reg    <= neg_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> phase_reg == PH_IDLE)
        else $error("arith unit started while busy");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STEP && op_reg == pms_pkg::OP_DIV)
            |-> pms_pkg::T_W'(rem_reg) < dvs1_reg)
        else $error("partial remainder not below divisor");

endmodule

// File: src/pid_motor_speed_loop.sv
// PID motor speed loop: tick sequencer, loop state and result register.
`timescale 1ns / 1ps

// Usage
// Config: write target_speed, gain_p, gain_i, gain_d through cfg_we/cfg_addr/cfg_wdata
// while the loop is idle; each write lands at the clock edge where cfg_we is high.
// Input: one beat per encoder tick (s_valid/s_ready) with now_ms and distance_sample.
// A tick whose gap to the previous one is zero or above 500 ms only records time
// and distance and gives no result.
// Any other tick produces one result beat (m_valid/m_ready): dir_a, dir_b and duty.
// Each in-window tick runs through the single radix-4 multiply/divide unit, which
// runs three 24-step divisions, three 12-step gain multiplies and a 13-step gap
// multiply one after another; s_ready is low while a tick is in work.
// A stalled receiver holds the result in the output register; the next tick is
// still taken, and its result waits in the final step until the register frees.
// Reset clears state, target, gains, timestamp, previous distance, integral, previous error and level.

module pid_motor_speed_loop #(
    parameter int TIME_BITS = pms_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pms_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pms_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pms_pkg::out_t                   m_data
);

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_PREP       = 13'b0000000000010,
        S_WAIT_SPEED = 13'b0000000000100,
        S_ERR        = 13'b0000000001000,
        S_MULG       = 13'b0000000010000,
        S_WAIT_MULG  = 13'b0000000100000,
        S_WAIT_DERIV = 13'b0000001000000,
        S_WAIT_ITERM = 13'b0000010000000,
        S_WAIT_MI    = 13'b0000100000000,
        S_WAIT_MP    = 13'b0001000000000,
        S_WAIT_MD    = 13'b0010000000000,
        S_LEVEL      = 13'b0100000000000,
        S_CLAMP      = 13'b1000000000000
    } state_t;

    function automatic logic signed [pms_pkg::ACC_W-1:0] sat_w(
        input logic signed [pms_pkg::ACC_W-1:0] v,
        input int                               n
    );
        logic signed [pms_pkg::ACC_W-1:0] hi;
        logic signed [pms_pkg::ACC_W-1:0] lo;
        hi = (pms_pkg::ACC_W'(64'sd1) <<< (n - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // x * 1000 as x*1024 - x*16 - x*8
    function automatic logic signed [pms_pkg::ARG_W-1:0] times_1000(
        input logic signed [pms_pkg::DIFF_W-1:0] x
    );
        logic signed [pms_pkg::ARG_W-1:0] w;
        w = pms_pkg::ARG_W'(x);
        return (w <<< 10) - (w <<< 4) - (w <<< 3);
    endfunction

    state_t                                 state_reg, state_next;

    logic signed [pms_pkg::CFG_W-1:0]       target_reg, target_next;
    logic signed [pms_pkg::CFG_W-1:0]       kp_reg, kp_next;
    logic signed [pms_pkg::CFG_W-1:0]       ki_reg, ki_next;
    logic signed [pms_pkg::CFG_W-1:0]       kd_reg, kd_next;

    logic [TIME_BITS-1:0]                   last_time_reg, last_time_next;
    logic signed [pms_pkg::POS_W-1:0]       prev_dist_reg, prev_dist_next;
    logic signed [pms_pkg::INTEG_W-1:0]     integ_reg, integ_next;
    logic signed [pms_pkg::ERR_W-1:0]       prev_err_reg, prev_err_next;
    logic signed [pms_pkg::LVL_W-1:0]       level_reg, level_next;
    logic                                   m_valid_reg, m_valid_next;

    logic [pms_pkg::GAP_W-1:0]              gap_reg, gap_next;
    logic signed [pms_pkg::DIFF_W-1:0]      diff_reg, diff_next;
    logic signed [pms_pkg::ERR_W-1:0]       speed_reg, speed_next;
    logic signed [pms_pkg::ERR_W-1:0]       err_reg, err_next;
    logic signed [pms_pkg::DIFF_W-1:0]      ediff_reg, ediff_next;
    logic signed [pms_pkg::DERIV_W-1:0]     deriv_reg, deriv_next;
    logic signed [pms_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic signed [pms_pkg::LVL_W-1:0]       lvl_reg, lvl_next;
    pms_pkg::out_t                          out_reg, out_next;

    logic [TIME_BITS-1:0]                   gap_full;
    logic                                   gap_ok;
    logic                                   in_beat;
    logic                                   out_free;
    logic signed [pms_pkg::LVL_W-1:0]       lvl_c;
    logic signed [pms_pkg::LVL_W-1:0]       lvl_neg;
    logic signed [pms_pkg::ACC_W-1:0]       res;

    pms_pkg::arith_req_t                    req;
    pms_pkg::arith_rsp_t                    rsp;

    pms_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign gap_full = s_data.now_ms[TIME_BITS-1:0] - last_time_reg;
    assign gap_ok   = (gap_full != '0) && (gap_full <= TIME_BITS'(pms_pkg::GAP_LIMIT_MS));
    assign out_free = !m_valid_reg || m_ready;
    assign res      = $signed(rsp.result);

    // clamp of the new level
    always_comb begin
        if (target_reg == '0) begin
            lvl_c = '0;
        end else if (lvl_reg > 0) begin
            if (lvl_reg < pms_pkg::LEVEL_MIN) begin
                lvl_c = pms_pkg::LEVEL_MIN;
            end else if (lvl_reg > pms_pkg::LEVEL_MAX) begin
                lvl_c = pms_pkg::LEVEL_MAX;
            end else begin
                lvl_c = lvl_reg;
            end
        end else if (lvl_reg < 0) begin
            if (lvl_reg > -pms_pkg::LEVEL_MIN) begin
                lvl_c = -pms_pkg::LEVEL_MIN;
            end else if (lvl_reg < -pms_pkg::LEVEL_MAX) begin
                lvl_c = -pms_pkg::LEVEL_MAX;
            end else begin
                lvl_c = lvl_reg;
            end
        end else begin
            lvl_c = '0;
        end
        lvl_neg = -lvl_c;
    end

    always_comb begin
        state_next     = state_reg;
        target_next    = target_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        kd_next        = kd_reg;
        last_time_next = last_time_reg;
        prev_dist_next = prev_dist_reg;
        integ_next     = integ_reg;
        prev_err_next  = prev_err_reg;
        level_next     = level_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        gap_next       = gap_reg;
        diff_next      = diff_reg;
        speed_next     = speed_reg;
        err_next       = err_reg;
        ediff_next     = ediff_reg;
        deriv_next     = deriv_reg;
        sum_next       = sum_reg;
        lvl_next       = lvl_reg;
        out_next       = out_reg;

        req.start = 1'b0;
        req.op    = pms_pkg::OP_MUL;
        req.steps = '0;
        req.a     = '0;
        req.b     = '0;

        if (cfg_we) begin
            case (cfg_addr)
                pms_pkg::CFG_TARGET: target_next = $signed(cfg_wdata);
                pms_pkg::CFG_GAIN_P: kp_next     = $signed(cfg_wdata);
                pms_pkg::CFG_GAIN_I: ki_next     = $signed(cfg_wdata);
                pms_pkg::CFG_GAIN_D: kd_next     = $signed(cfg_wdata);
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    last_time_next = s_data.now_ms[TIME_BITS-1:0];
                    prev_dist_next = $signed(s_data.distance_sample);
                    gap_next       = gap_full[pms_pkg::GAP_W-1:0];
                    diff_next      = pms_pkg::DIFF_W'($signed(s_data.distance_sample))
                                   - pms_pkg::DIFF_W'(prev_dist_reg);
                    if (gap_ok) begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP: begin
                req.start  = 1'b1;
                req.op     = pms_pkg::OP_DIV;
                req.steps  = pms_pkg::STEP_W'(pms_pkg::DIV_STEPS);
                req.a      = times_1000(diff_reg);
                req.b      = pms_pkg::B_W'(gap_reg);
                state_next = S_WAIT_SPEED;
            end
            S_WAIT_SPEED: begin
                if (rsp.done) begin
                    speed_next = pms_pkg::ERR_W'(sat_w(res, pms_pkg::ERR_W));
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                err_next   = pms_pkg::ERR_W'(sat_w(pms_pkg::ACC_W'(target_reg)
                                                   - pms_pkg::ACC_W'(speed_reg),
                                                   pms_pkg::ERR_W));
                state_next = S_MULG;
            end
            S_MULG: begin
                // gap sits at the top of the multiplier: walk its digits, then zero
                // digits that scale by 65536 so the final shift leaves err * gap
                req.start  = 1'b1;
                req.op     = pms_pkg::OP_MUL;
                req.steps  = pms_pkg::STEP_W'(pms_pkg::MULG_STEPS);
                req.a      = pms_pkg::ARG_W'(err_reg);
                req.b      = {1'b0, gap_reg,
                              {(pms_pkg::B_W - 1 - pms_pkg::GAP_W){1'b0}}};
                ediff_next = pms_pkg::DIFF_W'(err_reg) - pms_pkg::DIFF_W'(prev_err_reg);
                state_next = S_WAIT_MULG;
            end
            S_WAIT_MULG: begin
                if (rsp.done) begin
                    integ_next = pms_pkg::INTEG_W'(sat_w(pms_pkg::ACC_W'(integ_reg) + res,
                                                         pms_pkg::INTEG_W));
                    req.start  = 1'b1;
                    req.op     = pms_pkg::OP_DIV;
                    req.steps  = pms_pkg::STEP_W'(pms_pkg::DIV_STEPS);
                    req.a      = times_1000(ediff_reg);
                    req.b      = pms_pkg::B_W'(gap_reg);
                    state_next = S_WAIT_DERIV;
                end
            end
            S_WAIT_DERIV: begin
                if (rsp.done) begin
                    deriv_next = pms_pkg::DERIV_W'(sat_w(res, pms_pkg::DERIV_W));
                    req.start  = 1'b1;
                    req.op     = pms_pkg::OP_DIV;
                    req.steps  = pms_pkg::STEP_W'(pms_pkg::DIV_STEPS);
                    req.a      = integ_reg;
                    req.b      = pms_pkg::B_W'(pms_pkg::ITERM_DIV);
                    state_next = S_WAIT_ITERM;
                end
            end
            S_WAIT_ITERM: begin
                if (rsp.done) begin
                    req.start  = 1'b1;
                    req.op     = pms_pkg::OP_MUL;
                    req.steps  = pms_pkg::STEP_W'(pms_pkg::MUL_STEPS);
                    req.a      = pms_pkg::ARG_W'(res);
                    req.b      = ki_reg;
                    state_next = S_WAIT_MI;
                end
            end
            S_WAIT_MI: begin
                if (rsp.done) begin
                    sum_next   = pms_pkg::SUM_W'(res);
                    req.start  = 1'b1;
                    req.op     = pms_pkg::OP_MUL;
                    req.steps  = pms_pkg::STEP_W'(pms_pkg::MUL_STEPS);
                    req.a      = pms_pkg::ARG_W'(err_reg);
                    req.b      = kp_reg;
                    state_next = S_WAIT_MP;
                end
            end
            S_WAIT_MP: begin
                if (rsp.done) begin
                    sum_next   = sum_reg + pms_pkg::SUM_W'(res);
                    req.start  = 1'b1;
                    req.op     = pms_pkg::OP_MUL;
                    req.steps  = pms_pkg::STEP_W'(pms_pkg::MUL_STEPS);
                    req.a      = pms_pkg::ARG_W'(deriv_reg);
                    req.b      = kd_reg;
                    state_next = S_WAIT_MD;
                end
            end
            S_WAIT_MD: begin
                if (rsp.done) begin
                    sum_next   = sum_reg + pms_pkg::SUM_W'(res);
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL: begin
                lvl_next   = pms_pkg::LVL_W'(sat_w(pms_pkg::ACC_W'(level_reg)
                                                   + pms_pkg::ACC_W'(sum_reg),
                                                   pms_pkg::LVL_W));
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                // hold here until the result register frees
                if (out_free) begin
                    level_next    = lvl_c;
                    prev_err_next = err_reg;
                    m_valid_next  = 1'b1;
                    if (lvl_c > 0) begin
                        out_next.dir_a = 1'b1;
                        out_next.dir_b = 1'b0;
                        out_next.duty  = lvl_c[15:8];
                    end else begin
                        out_next.dir_a = 1'b0;
                        out_next.dir_b = 1'b1;
                        out_next.duty  = lvl_neg[15:8];
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            target_reg    <= '0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            last_time_reg <= '0;
            prev_dist_reg <= '0;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            level_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            last_time_reg <= last_time_next;
            prev_dist_reg <= prev_dist_next;
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
            level_reg     <= level_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gap_reg   <= gap_next;
        diff_reg  <= diff_next;
        speed_reg <= speed_next;
        err_reg   <= err_next;
        ediff_reg <= ediff_next;
        deriv_reg <= deriv_next;
        sum_reg   <= sum_next;
        lvl_reg   <= lvl_next;
        out_reg   <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_busy_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && gap_ok) |=> !s_ready)
        else $error("new tick taken while previous one in work");

    a_dir_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg.dir_a != out_reg.dir_b))
        else $error("direction lines not complementary");

    a_duty_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.dir_a) |-> (out_reg.duty >= 8'd170))
        else $error("forward duty below clamp floor");

    a_clamp_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLAMP && !m_valid_reg) |=> m_valid_reg)
        else $error("result not loaded from final step");

endmodule
